[hw/rtl/sjd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Smoothed joint drive package
// Shared types, constants and a helper function for the joint drive block.
// ----------------------------------------------------------------------------
package sjd_pkg;

  localparam int HISTORY_DEPTH_DEFAULT = 8;
  localparam int CMD_W                 = 16;
  localparam int POS_W                 = 12;
  localparam int WIDTH_W               = 11;
  localparam int CFG_ADDR_W            = 2;
  localparam int CFG_DATA_W            = 12;
  localparam int MID_DEPTH             = 2;
  localparam int OUT_DEPTH             = 4;
  localparam int OUT_LEVEL_W           = $clog2(OUT_DEPTH + 1);

  localparam logic [WIDTH_W-1:0] NEUTRAL_WIDTH = 11'd1500;
  localparam logic [CMD_W-1:0]   NEUTRAL_CMD   = 16'd1500;
  localparam logic [CMD_W-1:0]   WIDTH_MIN     = 16'd1000;
  localparam logic [CMD_W-1:0]   WIDTH_MAX     = 16'd2000;

  localparam logic [CFG_DATA_W-1:0] LIMIT_OFFSET_RESET = 12'd50;
  localparam logic [CFG_DATA_W-1:0] LOWER_START_RESET  = 12'd0;
  localparam logic [CFG_DATA_W-1:0] UPPER_START_RESET  = 12'd4095;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LIMIT_OFFSET = 2'd0,
    REG_LOWER_START  = 2'd1,
    REG_UPPER_START  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       command_high;
    logic [7:0]       command_low;
    logic [POS_W-1:0] position_sample;
    logic             lower_stop_pressed;
    logic             upper_stop_pressed;
  } item_t;

  typedef struct packed {
    logic               drive_write;
    logic [WIDTH_W-1:0] drive_width;
    logic               mean_out_of_range;
  } result_t;

  typedef struct packed {
    logic kind;
    logic idle_write;
    logic at_lower;
    logic at_upper;
  } front_flags_t;

  localparam int FLAGS_W = $bits(front_flags_t);

  // Signed command halved towards zero, offset to the neutral width.
  function automatic logic [CMD_W-1:0] form_command(input logic [7:0] hi,
                                                    input logic [7:0] lo);
    logic [CMD_W:0] ext;
    logic [CMD_W:0] half;
    ext  = {hi[7], hi, lo} + {{CMD_W{1'b0}}, hi[7]};
    half = $signed(ext) >>> 1;
    return half[CMD_W-1:0] + NEUTRAL_CMD;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sjd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out store of fixed-width words with full, empty and level.
// ----------------------------------------------------------------------------
module sjd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [WIDTH-1:0]               wdata,
  output logic                                full,
  input  wire logic                           pop,
  output logic [WIDTH-1:0]                    rdata,
  output logic                                empty,
  output logic [$clog2(DEPTH+1)-1:0]          level
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEVEL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == LEVEL_W'(DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sjd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Joint drive front end
// Holds configuration and soft limits, keeps the command history and its
// running sum, and classifies each accepted word against the limits.
// ----------------------------------------------------------------------------
module sjd_front import sjd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  accept,
  input  wire item_t                                 item,
  input  wire logic                                  cfg_write,
  input  wire logic [CFG_ADDR_W-1:0]                 cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]                 cfg_data,
  output front_flags_t                               flags,
  output logic [CMD_W+$clog2(HISTORY_DEPTH)-1:0]     sum
);

  localparam int SUM_W = CMD_W + $clog2(HISTORY_DEPTH);

  logic [CFG_DATA_W-1:0] limit_offset;
  logic [CMD_W-1:0]      lower_limit;
  logic [CMD_W-1:0]      upper_limit;
  logic [CMD_W-1:0]      history [HISTORY_DEPTH];
  logic [SUM_W-1:0]      history_sum;
  logic [SUM_W-1:0]      history_sum_next;
  logic [CMD_W-1:0]      cmd;
  logic [CMD_W-1:0]      sample_ext;
  logic                  lower_hit;
  logic                  upper_hit;
  logic                  cmd_tick;

  assign cmd        = form_command(item.command_high, item.command_low);
  assign sample_ext = {{(CMD_W-POS_W){1'b0}}, item.position_sample};
  assign lower_hit  = (sample_ext <= lower_limit);
  assign upper_hit  = (sample_ext >= upper_limit);
  assign cmd_tick   = accept && item.kind;

  assign history_sum_next = history_sum
                          - {{(SUM_W-CMD_W){1'b0}}, history[HISTORY_DEPTH-1]}
                          + {{(SUM_W-CMD_W){1'b0}}, cmd};

  always_comb begin
    flags.kind       = item.kind;
    flags.idle_write = lower_hit || upper_hit;
    priority if (item.lower_stop_pressed) begin
      flags.at_lower = 1'b1;
      flags.at_upper = 1'b0;
    end else if (item.upper_stop_pressed) begin
      flags.at_lower = 1'b0;
      flags.at_upper = 1'b1;
    end else begin
      flags.at_lower = lower_hit;
      flags.at_upper = !lower_hit && upper_hit;
    end
  end

  assign sum = item.kind ? history_sum_next : history_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_offset <= LIMIT_OFFSET_RESET;
      lower_limit  <= {{(CMD_W-CFG_DATA_W){1'b0}}, LOWER_START_RESET};
      upper_limit  <= {{(CMD_W-CFG_DATA_W){1'b0}}, UPPER_START_RESET};
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_LIMIT_OFFSET: limit_offset <= cfg_data;
        REG_LOWER_START:  lower_limit  <= {{(CMD_W-CFG_DATA_W){1'b0}}, cfg_data};
        REG_UPPER_START:  upper_limit  <= {{(CMD_W-CFG_DATA_W){1'b0}}, cfg_data};
        default: ;
      endcase
    end else if (cmd_tick) begin
      priority if (item.lower_stop_pressed) begin
        lower_limit <= sample_ext + {{(CMD_W-CFG_DATA_W){1'b0}}, limit_offset};
      end else if (item.upper_stop_pressed) begin
        upper_limit <= sample_ext - {{(CMD_W-CFG_DATA_W){1'b0}}, limit_offset};
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_sum <= SUM_W'(NEUTRAL_CMD * HISTORY_DEPTH);
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= NEUTRAL_CMD;
      end
    end else if (cmd_tick) begin
      history_sum <= history_sum_next;
      history[0]  <= cmd;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sjd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Joint drive back end
// Takes classified words, forms the history mean by reciprocal multiply and
// selects the pulse width, feeding the result queue.
// ----------------------------------------------------------------------------
module sjd_back import sjd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_empty,
  input  wire front_flags_t                          q_flags,
  input  wire logic [CMD_W+$clog2(HISTORY_DEPTH)-1:0] q_sum,
  output logic                                       q_pop,
  input  wire logic [OUT_LEVEL_W-1:0]                out_level,
  output logic                                       out_push,
  output result_t                                    out_result
);

  localparam int SUM_W  = CMD_W + $clog2(HISTORY_DEPTH);
  localparam int SHIFT  = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  logic               s1_valid;
  front_flags_t       s1_flags;
  logic [PROD_W-1:0]  s1_prod;
  logic [CMD_W-1:0]   mean;
  logic               in_range;
  logic [OUT_LEVEL_W:0] occupancy;

  assign occupancy = {1'b0, out_level} + {{OUT_LEVEL_W{1'b0}}, s1_valid};
  assign q_pop     = !q_empty && (occupancy < (OUT_LEVEL_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_flags <= q_flags;
      s1_prod  <= {{(SUM_W+1){1'b0}}, q_sum} * {{SUM_W{1'b0}}, RECIP};
    end
  end

  assign mean     = s1_prod[SHIFT +: CMD_W];
  assign in_range = (mean >= WIDTH_MIN) && (mean <= WIDTH_MAX);
  assign out_push = s1_valid;

  always_comb begin
    out_result.drive_write       = 1'b1;
    out_result.drive_width       = NEUTRAL_WIDTH;
    out_result.mean_out_of_range = 1'b0;
    if (!s1_flags.kind) begin
      out_result.drive_write = s1_flags.idle_write;
    end else begin
      out_result.mean_out_of_range = !in_range;
      priority if (s1_flags.at_lower && (mean < NEUTRAL_CMD)) begin
        out_result.drive_width = NEUTRAL_WIDTH;
      end else if (s1_flags.at_upper && (mean > NEUTRAL_CMD)) begin
        out_result.drive_width = NEUTRAL_WIDTH;
      end else if (in_range) begin
        out_result.drive_width = mean[WIDTH_W-1:0];
      end else begin
        out_result.drive_width = NEUTRAL_WIDTH;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/smoothed_joint_drive_with_soft_limits.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Smoothed joint drive with soft limits
// Control ticks go in through a push/full queue port and one result word per
// tick comes out through an empty/pop queue port. A tick is taken on a clock
// edge with push high and full low; the result at the head is taken on an
// edge with pop high and empty low. Limits and the end-stop margin are set
// through the cfg_write/cfg_addr/cfg_data port; the user must do so while
// no tick is in flight, as the block itself does not enforce it. One tick
// is taken every cycle while full is low; the history sum is updated as the
// tick is taken and the back end forms the mean by one registered multiply.
// A short queue separates front end and back end, and a four-word queue
// holds results. When pop stays low the result queue fills, then the inner
// queue, and full rises; nothing is dropped. Synchronous reset empties both
// queues, sets every history entry to neutral (1500) and loads the reset
// values of the margin and both soft limits.
// ----------------------------------------------------------------------------
module smoothed_joint_drive_with_soft_limits import sjd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire item_t                 item,
  output logic                       full,
  output logic                       empty,
  input  wire logic                  pop,
  output result_t                    result,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = CMD_W + $clog2(HISTORY_DEPTH);
  localparam int MID_W = FLAGS_W + SUM_W;

  logic                   accept;
  front_flags_t           front_flags;
  logic [SUM_W-1:0]       front_sum;
  logic [MID_W-1:0]       mid_rdata;
  logic                   mid_full;
  logic                   mid_empty;
  logic                   mid_pop;
  logic [OUT_LEVEL_W-1:0] out_level;
  logic                   out_push;
  result_t                out_result;
  logic                   out_full;
  logic [$bits(result_t)-1:0] out_rdata;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  sjd_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .flags     (front_flags),
    .sum       (front_sum)
  );

  sjd_queue #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata ({front_flags, front_sum}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .level ()
  );

  sjd_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (mid_empty),
    .q_flags    (front_flags_t'(mid_rdata[MID_W-1:SUM_W])),
    .q_sum      (mid_rdata[SUM_W-1:0]),
    .q_pop      (mid_pop),
    .out_level  (out_level),
    .out_push   (out_push),
    .out_result (out_result)
  );

  sjd_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .level (out_level)
  );

  assign result = result_t'(out_rdata);

  // The back end never pushes into a full result queue.
  logic unused_out_full;
  assign unused_out_full = out_full;

endmodule
`default_nettype wire

[tb/smoothed_joint_drive_with_soft_limits_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed joint drive with soft limits: self-checking test
// Control ticks are pushed into the block and each drive word that comes back
// is checked against a local prediction of the command ring, its mean and the
// soft limit logic. A directed set of ticks is followed by register extremes,
// an output stall that fills the block, and random phases with new limits.
// ----------------------------------------------------------------------------
module smoothed_joint_drive_with_soft_limits_test;
  import sjd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  item_t item = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [CFG_DATA_W-1:0] margin = LIMIT_OFFSET_RESET;
  logic [CMD_W-1:0] lower_lim = {4'd0, LOWER_START_RESET};
  logic [CMD_W-1:0] upper_lim = {4'd0, UPPER_START_RESET};
  logic [CMD_W-1:0] cmd_ring [HISTORY_DEPTH_DEFAULT];
  int ring_slot = 0;
  int ring_sum = int'(NEUTRAL_CMD) * HISTORY_DEPTH_DEFAULT;

  result_t expected_drives [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit sender_idles = 1'b1;
  logic receiver_idles = 1'b1;
  logic pop_hold = 1'b0;

  smoothed_joint_drive_with_soft_limits uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t next_drive_result(input item_t tick);
    result_t r;
    logic [CMD_W-1:0] pos;
    logic [CMD_W-1:0] cmd;
    int signed_cmd;
    int mean;
    logic near_lower;
    logic near_upper;
    r.drive_write = 1'b0;
    r.drive_width = NEUTRAL_WIDTH;
    r.mean_out_of_range = 1'b0;
    pos = {4'd0, tick.position_sample};
    if (tick.kind == 1'b0) begin
      r.drive_write = (pos <= lower_lim) || (pos >= upper_lim);
    end else begin
      signed_cmd = $signed({tick.command_high, tick.command_low});
      cmd = CMD_W'(signed_cmd / 2 + int'(NEUTRAL_CMD));
      ring_sum = ring_sum - int'(cmd_ring[ring_slot]) + int'(cmd);
      cmd_ring[ring_slot] = cmd;
      ring_slot = (ring_slot + 1) % HISTORY_DEPTH_DEFAULT;
      mean = ring_sum / HISTORY_DEPTH_DEFAULT;
      r.mean_out_of_range = (mean < int'(WIDTH_MIN)) || (mean > int'(WIDTH_MAX));
      r.drive_write = 1'b1;
      if (tick.lower_stop_pressed) begin
        lower_lim = pos + CMD_W'(margin);
        near_lower = 1'b1;
        near_upper = 1'b0;
      end else if (tick.upper_stop_pressed) begin
        upper_lim = pos - CMD_W'(margin);
        near_lower = 1'b0;
        near_upper = 1'b1;
      end else begin
        near_lower = pos <= lower_lim;
        near_upper = !near_lower && pos >= upper_lim;
      end
      if (!((near_lower && mean < int'(NEUTRAL_CMD)) ||
            (near_upper && mean > int'(NEUTRAL_CMD)) || r.mean_out_of_range)) begin
        r.drive_width = WIDTH_W'(mean);
      end
    end
    return r;
  endfunction

  function automatic item_t make_tick(input logic kind, input logic [15:0] cmd,
                                      input int sample, input logic lo, input logic up);
    item_t t;
    t.kind = kind;
    {t.command_high, t.command_low} = cmd;
    t.position_sample = POS_W'(sample);
    t.lower_stop_pressed = lo;
    t.upper_stop_pressed = up;
    return t;
  endfunction

  function automatic item_t random_tick();
    item_t t;
    int cmd;
    t.kind = ($urandom_range(99) < 75);
    if ($urandom_range(99) < 85) begin
      cmd = int'($urandom_range(2000)) - 1000;
    end else begin
      cmd = int'($urandom);
    end
    {t.command_high, t.command_low} = cmd[15:0];
    case ($urandom_range(3))
      0: begin
        t.position_sample = lower_lim[POS_W-1:0] + POS_W'($urandom_range(8)) - 12'd4;
      end
      1: begin
        t.position_sample = upper_lim[POS_W-1:0] + POS_W'($urandom_range(8)) - 12'd4;
      end
      default: begin
        t.position_sample = POS_W'($urandom);
      end
    endcase
    t.lower_stop_pressed = ($urandom_range(99) < 5);
    t.upper_stop_pressed = ($urandom_range(99) < 5);
    return t;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] limit_value(input int lo, input int hi);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic send_tick(input item_t tick);
    while (sender_idles && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= tick;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_drives.push_back(next_drive_result(tick));
  endtask

  task automatic wait_for_drive_results();
    push <= 1'b0;
    do @(posedge clk); while (expected_drives.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LIMIT_OFFSET: margin = v;
      REG_LOWER_START: lower_lim = {4'd0, v};
      REG_UPPER_START: upper_lim = {4'd0, v};
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] offset,
                            input logic [CFG_DATA_W-1:0] lower,
                            input logic [CFG_DATA_W-1:0] upper);
    wait_for_drive_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_LIMIT_OFFSET, offset);
    write_reg(REG_LOWER_START, lower);
    write_reg(REG_UPPER_START, upper);
    if ($urandom_range(3) == 0) begin
      write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    end
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
    if (mismatch_count < 10) begin
      $display("%0t: %s expected %0d, got %0d", $realtime, field, want, got);
    end
    mismatch_count++;
  endtask

  task automatic test_directed_ticks();
    send_tick(make_tick(1'b0, 16'hFFFF, 0, 1'b1, 1'b1));
    send_tick(make_tick(1'b0, 16'h0000, 4095, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 16'h5AA5, 2048, 1'b1, 1'b0));
    send_tick(make_tick(1'b1, 16'h0000, 2048, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'h7FFF, 2048, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'h8000, 2048, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'hFFFF, 2048, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'h0001, 2048, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'hFFFD, 2048, 1'b0, 1'b0));
    repeat (HISTORY_DEPTH_DEFAULT) send_tick(make_tick(1'b1, 16'hFDA8, 2048, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'hFDA8, 100, 1'b1, 1'b0));
    send_tick(make_tick(1'b1, 16'hFDA8, 150, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 16'h0000, 151, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'h0800, 4000, 1'b0, 1'b1));
    send_tick(make_tick(1'b1, 16'h0800, 3950, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'h07D0, 30, 1'b1, 1'b1));
    send_tick(make_tick(1'b1, 16'h07D0, 30, 1'b0, 1'b1));
    wait_for_drive_results();
  endtask

  task automatic test_register_extremes();
    set_limits('1, '1, '0);
    send_tick(make_tick(1'b0, 16'h0000, 0, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 16'h0000, 4095, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'h0190, 2000, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 16'hFE70, 4095, 1'b1, 1'b0));
    send_tick(make_tick(1'b1, 16'h0190, 0, 1'b0, 1'b1));
    send_tick(make_tick(1'b0, 16'h0000, 2000, 1'b0, 1'b0));
    wait_for_drive_results();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    set_limits('0, '0, '1);
    send_tick(make_tick(1'b1, 16'h0190, 4095, 1'b0, 1'b1));
    send_tick(make_tick(1'b1, 16'hFE70, 0, 1'b1, 1'b0));
    send_tick(make_tick(1'b0, 16'h0000, 0, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 16'h0000, 2000, 1'b0, 1'b0));
    wait_for_drive_results();
  endtask

  task automatic test_output_backpressure();
    set_limits(12'd50, 12'd200, 12'd3900);
    sender_idles = 1'b0;
    fork
      begin
        repeat (40) send_tick(random_tick());
      end
      begin
        pop_hold <= 1'b1;
        repeat (80) @(posedge clk);
        pop_hold <= 1'b0;
      end
    join
    wait_for_drive_results();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_ticks();
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      set_limits(limit_value(0, 200), limit_value(0, 1500), limit_value(2500, 4095));
      if (phase == 5) begin
        sender_idles = 1'b0;
        receiver_idles <= 1'b0;
      end
      repeat (phase == 5 ? 300 : 125) send_tick(random_tick());
      sender_idles = 1'b1;
      receiver_idles <= 1'b1;
    end
    wait_for_drive_results();
  endtask

  always @(posedge clk) begin
    if (rst || pop_hold) begin
      pop <= 1'b0;
    end else if (receiver_idles) begin
      pop <= ($urandom_range(99) >= 35);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_drive
    result_t want;
    if (!rst && pop && !empty) begin
      if (expected_drives.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: drive word with none expected: %p", $realtime, result);
        end
        mismatch_count++;
      end else begin
        want = expected_drives.pop_front();
        if (result.drive_write !== want.drive_write) begin
          report_mismatch("drive_write", 16'(want.drive_write), 16'(result.drive_write));
        end
        if (result.drive_width !== want.drive_width) begin
          report_mismatch("drive_width", 16'(want.drive_width), 16'(result.drive_width));
        end
        if (result.mean_out_of_range !== want.mean_out_of_range) begin
          report_mismatch("mean_out_of_range", 16'(want.mean_out_of_range),
                          16'(result.mean_out_of_range));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < HISTORY_DEPTH_DEFAULT; i++) begin
      cmd_ring[i] = NEUTRAL_CMD;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_ticks();
    test_register_extremes();
    test_output_backpressure();
    test_random_ticks();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_drives.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[smoothed_joint_drive_with_soft_limits.f]
hw/rtl/sjd_pkg.sv
hw/rtl/sjd_queue.sv
hw/rtl/sjd_front.sv
hw/rtl/sjd_back.sv
hw/rtl/smoothed_joint_drive_with_soft_limits.sv
tb/smoothed_joint_drive_with_soft_limits_test.sv
